// File: design/sfd_pkg.sv
// Shared types and constants for the SLIP frame decoder.
// Depends on nothing; every other design file imports it.

package sfd_pkg;

  localparam logic [7:0] SEP_BYTE     = 8'hC0;
  localparam logic [7:0] ESC_BYTE     = 8'hDB;
  localparam logic [7:0] ESC_SEP_BYTE = 8'hDC;
  localparam logic [7:0] ESC_ESC_BYTE = 8'hDD;

  localparam int unsigned MaxLenW  = 16;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned IdleW    = 21;
  localparam int unsigned CfgDataW = 20;

  localparam logic [MaxLenW-1:0]  MAX_FRAME_LEN_RST = 16'd256;
  localparam logic [TimeoutW-1:0] IDLE_TIMEOUT_RST  = 20'd1000;

  localparam logic       REQ_BYTE = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  localparam logic       CFG_MAX_FRAME_LEN = 1'b0;
  localparam logic       CFG_IDLE_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_END      = 2'd1,
    KIND_BADESC   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } sfd_kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } sfd_in_beat_t;

  typedef struct packed {
    sfd_kind_e          out_kind;
    logic [7:0]         out_byte;
    logic [MaxLenW-1:0] frame_length;
  } sfd_out_beat_t;

  typedef struct packed {
    logic [MaxLenW-1:0]  max_frame_len;
    logic [TimeoutW-1:0] idle_timeout;
  } sfd_cfg_t;

  typedef struct packed {
    logic               in_frame;
    logic               escape_pending;
    logic [MaxLenW-1:0] payload_count;
    logic [IdleW-1:0]   idle_ticks;
  } sfd_state_t;

endpackage

// File: design/sfd_cfg.sv
// Configuration registers of the SLIP frame decoder.
// Depends on sfd_pkg for the register layout and reset values.

module sfd_cfg import sfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output sfd_cfg_t            cfg_o
);

  sfd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_len <= MAX_FRAME_LEN_RST;
      cfg_q.idle_timeout  <= IDLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_wdata_i[MaxLenW-1:0];
        CFG_IDLE_TIMEOUT:  cfg_q.idle_timeout  <= cfg_wdata_i[TimeoutW-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/sfd_core.sv
// Single-pass decode of one beat: timeout, hunting, unescaping and limits.
// Depends on sfd_pkg; purely combinational, state is held by the top level.

module sfd_core import sfd_pkg::*; (
  input  sfd_in_beat_t  beat_i,
  input  sfd_state_t    state_i,
  input  sfd_cfg_t      cfg_i,
  output sfd_state_t    state_d_o,
  output logic          res_valid_o,
  output sfd_out_beat_t res_o
);

  always_comb begin
    sfd_state_t    st;
    sfd_out_beat_t res;
    logic          res_valid;
    logic          store;
    logic [7:0]    ch;

    st        = state_i;
    res       = '0;
    res_valid = 1'b0;
    store     = 1'b0;
    ch        = beat_i.rx_byte;

    if (beat_i.req_type == REQ_TICK) begin
      if (st.idle_ticks != {IdleW{1'b1}}) begin
        st.idle_ticks = st.idle_ticks + 1'b1;
      end
    end else begin
      if (state_i.idle_ticks > {1'b0, cfg_i.idle_timeout}) begin
        st.in_frame       = 1'b0;
        st.escape_pending = 1'b0;
        st.payload_count  = '0;
      end
      st.idle_ticks = '0;

      if (!st.in_frame) begin
        if (beat_i.rx_byte == SEP_BYTE) begin
          st.in_frame       = 1'b1;
          st.escape_pending = 1'b0;
          st.payload_count  = '0;
        end
      end else if (beat_i.rx_byte == SEP_BYTE) begin
        st.escape_pending = 1'b0;
        if (st.payload_count != '0) begin
          res_valid        = 1'b1;
          res.out_kind     = KIND_END;
          res.frame_length = st.payload_count;
          st.in_frame      = 1'b0;
          st.payload_count = '0;
        end
      end else if (st.escape_pending) begin
        st.escape_pending = 1'b0;
        if (beat_i.rx_byte == ESC_SEP_BYTE) begin
          ch    = SEP_BYTE;
          store = 1'b1;
        end else if (beat_i.rx_byte == ESC_ESC_BYTE) begin
          ch    = ESC_BYTE;
          store = 1'b1;
        end else begin
          res_valid        = 1'b1;
          res.out_kind     = KIND_BADESC;
          st.in_frame      = 1'b0;
          st.payload_count = '0;
        end
      end else if (beat_i.rx_byte == ESC_BYTE) begin
        st.escape_pending = 1'b1;
      end else begin
        store = 1'b1;
      end

      if (store) begin
        res_valid = 1'b1;
        if (st.payload_count < cfg_i.max_frame_len) begin
          st.payload_count = st.payload_count + 1'b1;
          res.out_kind     = KIND_DATA;
          res.out_byte     = ch;
        end else begin
          res.out_kind      = KIND_OVERFLOW;
          st.in_frame       = 1'b0;
          st.escape_pending = 1'b0;
          st.payload_count  = '0;
        end
      end
    end

    state_d_o   = st;
    res_valid_o = res_valid;
    res_o       = res;
  end

endmodule

// File: design/slip_frame_decoder.sv
// SLIP receive decoder: takes one line byte or time tick per beat and returns
// decoded payload bytes, frame ends with their length, and error beats.
// Depends on sfd_pkg, sfd_cfg and sfd_core.
//
// A beat is taken in every cycle in which input stall is low. It is held in an
// input register, decoded in one pass of logic against the frame state, and
// lands in the result register when that register is empty or not stalled,
// from which it is presented on the output port. Ticks and bytes that
// produce nothing leave no result beat. Input stall is raised only while the
// input register is full and the result register is full and stalled.
// Configuration writes must happen while no beat is in flight.

module slip_frame_decoder import sfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfd_in_beat_t        in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfd_out_beat_t       out_beat_o
);

  sfd_cfg_t      cfg;
  sfd_state_t    state_q, state_d;
  sfd_in_beat_t  s1_q;
  logic          s1_valid_q;
  sfd_out_beat_t out_q, res;
  logic          out_valid_q, res_valid;
  logic          out_ready, s1_adv, in_acc;

  sfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sfd_core u_core (
    .beat_i      (s1_q),
    .state_i     (state_q),
    .cfg_i       (cfg),
    .state_d_o   (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= res_valid;
        state_q     <= state_d;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_beat_i;
    end
    if (s1_adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.escape_pending |-> state_q.in_frame)
    else $error("escape pending outside a frame");

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.payload_count != '0) |-> state_q.in_frame)
    else $error("payload count held outside a frame");

  a_close_leaves_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res_valid && res.out_kind != KIND_DATA) |=> !state_q.in_frame)
    else $error("frame state kept after frame end or error");

  a_end_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.out_kind == KIND_END) |-> (out_beat_o.frame_length != '0))
    else $error("frame end with zero length");

  a_no_beat_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");
`endif

endmodule
